/* hdl/uds_pkg.sv */
package uds_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int OUT_FRAC          = 14;
  localparam int OUT_ONE           = 16384;
  localparam longint GAIN_Q30      = 652032874;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_HEMI   = 2'd0;
  localparam mode_t MODE_SPHERE = 2'd1;
  localparam mode_t MODE_CIRCLE = 2'd2;

  // Control that travels with every item down the pipeline.
  typedef struct packed {
    mode_t mode;
    logic  flip;
  } uds_ctl_t;

  // Both circle codes (the upper bit set) select unit circle behavior.
  function automatic logic is_circle(input mode_t m);
    is_circle = (m & MODE_CIRCLE) != MODE_HEMI;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turns.
  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:       atan_turn = 32'd536870912;
      1:       atan_turn = 32'd316933406;
      2:       atan_turn = 32'd167458907;
      3:       atan_turn = 32'd85004756;
      4:       atan_turn = 32'd42667331;
      5:       atan_turn = 32'd21354465;
      6:       atan_turn = 32'd10679838;
      7:       atan_turn = 32'd5340245;
      8:       atan_turn = 32'd2670163;
      9:       atan_turn = 32'd1335087;
      10:      atan_turn = 32'd667544;
      11:      atan_turn = 32'd333772;
      12:      atan_turn = 32'd166886;
      13:      atan_turn = 32'd83443;
      14:      atan_turn = 32'd41722;
      15:      atan_turn = 32'd20861;
      16:      atan_turn = 32'd10430;
      17:      atan_turn = 32'd5215;
      18:      atan_turn = 32'd2608;
      19:      atan_turn = 32'd1304;
      20:      atan_turn = 32'd652;
      21:      atan_turn = 32'd326;
      22:      atan_turn = 32'd163;
      23:      atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

  // CORDIC start value: the gain correction rounded to f fraction bits.
  function automatic logic signed [63:0] cordic_x0(input int f);
    logic signed [63:0] g;
    g = 64'(GAIN_Q30);
    cordic_x0 = (g + (64'sd1 <<< (29 - f))) >>> (30 - f);
  endfunction

  // Round half up from f fraction bits to Q2.14 and clamp to +-1.0.
  function automatic logic signed [15:0] to_q14(input logic signed [63:0] v, input int f);
    logic signed [63:0] q;
    if (f > OUT_FRAC) begin
      q = (v + (64'sd1 <<< (f - OUT_FRAC - 1))) >>> (f - OUT_FRAC);
    end else begin
      q = v <<< (OUT_FRAC - f);
    end
    if (q > 64'(OUT_ONE)) begin
      q = 64'(OUT_ONE);
    end
    if (q < -64'(OUT_ONE)) begin
      q = -64'(OUT_ONE);
    end
    to_q14 = q[15:0];
  endfunction

endpackage

/* hdl/uds_prep.sv */
module uds_prep import uds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vin,
  output logic                         up_ready,
  input  logic [15:0]                  u_in,
  input  logic [15:0]                  v_in,
  input  mode_t                        mode_in,
  input  logic                         dn_ready,
  output logic                         vout,
  output logic signed [31:0]           ang_out,
  output logic [2*FRAC_BITS+1:0]       n_out,
  output logic signed [FRAC_BITS+1:0]  zf_out,
  output uds_ctl_t                     ctl_out
);

  localparam int ZW = FRAC_BITS + 2;
  localparam int NW = 2 * FRAC_BITS + 2;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [31:0]   ang1_r, ang2_r, ang3_r;
  uds_ctl_t             ctl1_r, ctl2_r, ctl3_r;
  logic signed [ZW-1:0] zf1_r, zf2_r, zf3_r;
  logic signed [ZW-1:0] zz2_r;
  logic [NW-1:0]        n3_r;

  logic signed [17:0]     zq;
  logic signed [47:0]     zq_ext;
  logic signed [ZW-1:0]   zf_nxt;
  logic signed [2*ZW-1:0] zprod;
  logic signed [ZW:0]     d_diff;
  logic [NW-1:0]          n_nxt;
  uds_ctl_t               ctl_nxt;
  logic signed [31:0]     ang_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // Height in Q.16: v for the hemisphere, 2v - 1 for the sphere and circle modes.
  always_comb begin
    if (mode_in == MODE_HEMI) begin
      zq = {2'b00, v_in};
    end else begin
      zq = $signed({1'b0, v_in, 1'b0}) - 18'sd65536;
    end
    zq_ext = 48'(zq);
  end

  generate
    if (FRAC_BITS >= 16) begin : g_widen
      assign zf_nxt = ZW'(zq_ext <<< (FRAC_BITS - 16));
    end else begin : g_narrow
      assign zf_nxt = ZW'((zq_ext + (48'sd1 <<< (15 - FRAC_BITS))) >>> (16 - FRAC_BITS));
    end
  endgenerate

  // The angle is folded into [-1/4, 1/4) turn by adding half a turn.
  always_comb begin
    ctl_nxt.mode = mode_in;
    ctl_nxt.flip = u_in[15] ^ u_in[14];
    ang_nxt      = {u_in[14], u_in[14:0], 16'h0000};
  end

  assign zprod  = zf1_r * zf1_r;
  assign d_diff = (ZW+1)'(1 <<< FRAC_BITS) - (ZW+1)'(zz2_r);

  always_comb begin
    if (d_diff < 0) begin
      n_nxt = '0;
    end else begin
      n_nxt = NW'(d_diff) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= vin;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ang1_r <= ang_nxt;
      ctl1_r <= ctl_nxt;
      zf1_r  <= zf_nxt;
    end
    if (en2) begin
      ang2_r <= ang1_r;
      ctl2_r <= ctl1_r;
      zf2_r  <= zf1_r;
      zz2_r  <= ZW'(zprod >>> FRAC_BITS);
    end
    if (en3) begin
      ang3_r <= ang2_r;
      ctl3_r <= ctl2_r;
      zf3_r  <= zf2_r;
      n3_r   <= n_nxt;
    end
  end

  assign vout    = v3_r;
  assign ang_out = ang3_r;
  assign n_out   = n3_r;
  assign zf_out  = zf3_r;
  assign ctl_out = ctl3_r;

endmodule

/* hdl/uds_stage.sv */
module uds_stage import uds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IDX       = 0,
  parameter bit DO_ROT    = 1'b1,
  parameter bit DO_ROOT   = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vin,
  output logic                         up_ready,
  input  logic signed [FRAC_BITS+2:0]  x_in,
  input  logic signed [FRAC_BITS+2:0]  y_in,
  input  logic signed [31:0]           ang_in,
  input  logic [2*FRAC_BITS+1:0]       n_in,
  input  logic [2*FRAC_BITS+1:0]       res_in,
  input  logic signed [FRAC_BITS+1:0]  zf_in,
  input  uds_ctl_t                     ctl_in,
  input  logic                         dn_ready,
  output logic                         vout,
  output logic signed [FRAC_BITS+2:0]  x_out,
  output logic signed [FRAC_BITS+2:0]  y_out,
  output logic signed [31:0]           ang_out,
  output logic [2*FRAC_BITS+1:0]       n_out,
  output logic [2*FRAC_BITS+1:0]       res_out,
  output logic signed [FRAC_BITS+1:0]  zf_out,
  output uds_ctl_t                     ctl_out
);

  localparam int W   = FRAC_BITS + 3;
  localparam int NW  = 2 * FRAC_BITS + 2;
  localparam int BSH = DO_ROOT ? 2 * (FRAC_BITS - IDX) : 0;
  localparam logic [NW-1:0] ROOT_BIT = NW'(1) << BSH;
  localparam logic signed [31:0] ATAN = atan_turn(IDX);

  logic v_r;
  logic en;

  logic signed [W-1:0] x_r, y_r, x_nxt, y_nxt, x_shr, y_shr;
  logic signed [31:0]  ang_r, ang_nxt;
  logic [NW-1:0]       n_r, res_r, n_nxt, res_nxt, trial;
  logic signed [FRAC_BITS+1:0] zf_r;
  uds_ctl_t            ctl_r;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;

  // One rotation: turn toward zero residual angle.
  always_comb begin
    x_shr = x_in >>> IDX;
    y_shr = y_in >>> IDX;
    if (!DO_ROT) begin
      x_nxt   = x_in;
      y_nxt   = y_in;
      ang_nxt = ang_in;
    end else if (!ang_in[31]) begin
      x_nxt   = x_in - y_shr;
      y_nxt   = y_in + x_shr;
      ang_nxt = ang_in - ATAN;
    end else begin
      x_nxt   = x_in + y_shr;
      y_nxt   = y_in - x_shr;
      ang_nxt = ang_in + ATAN;
    end
  end

  // One bit of the restoring square root.
  always_comb begin
    trial = res_in + ROOT_BIT;
    if (!DO_ROOT) begin
      n_nxt   = n_in;
      res_nxt = res_in;
    end else if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + ROOT_BIT;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
      n_r   <= n_nxt;
      res_r <= res_nxt;
      zf_r  <= zf_in;
      ctl_r <= ctl_in;
    end
  end

  assign vout    = v_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign ang_out = ang_r;
  assign n_out   = n_r;
  assign res_out = res_r;
  assign zf_out  = zf_r;
  assign ctl_out = ctl_r;

endmodule

/* hdl/uds_post.sv */
module uds_post import uds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vin,
  output logic                         up_ready,
  input  logic signed [FRAC_BITS+2:0]  x_in,
  input  logic signed [FRAC_BITS+2:0]  y_in,
  input  logic [2*FRAC_BITS+1:0]       res_in,
  input  logic signed [FRAC_BITS+1:0]  zf_in,
  input  uds_ctl_t                     ctl_in,
  input  logic                         dn_ready,
  output logic                         vout,
  output logic signed [15:0]           dir_x,
  output logic signed [15:0]           dir_y,
  output logic signed [15:0]           dir_z
);

  localparam int W  = FRAC_BITS + 3;
  localparam int ZW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 2 + W;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [W-1:0]   c1_r, s1_r, px2_r, py2_r;
  logic [FRAC_BITS:0]    r1_r;
  logic signed [ZW-1:0]  zf1_r, zf2_r;
  uds_ctl_t              ctl1_r, ctl2_r;
  logic signed [15:0]    ox_r, oy_r, oz_r;
  logic signed [PW-1:0]  prod_x, prod_y;
  logic signed [W-1:0]   px_nxt, py_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign prod_x = $signed({1'b0, r1_r}) * c1_r;
  assign prod_y = $signed({1'b0, r1_r}) * s1_r;

  always_comb begin
    if (is_circle(ctl1_r.mode)) begin
      px_nxt = c1_r;
      py_nxt = s1_r;
    end else begin
      px_nxt = W'(prod_x >>> FRAC_BITS);
      py_nxt = W'(prod_y >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= vin;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      c1_r   <= ctl_in.flip ? -x_in : x_in;
      s1_r   <= ctl_in.flip ? -y_in : y_in;
      r1_r   <= res_in[FRAC_BITS:0];
      zf1_r  <= zf_in;
      ctl1_r <= ctl_in;
    end
    if (en2) begin
      px2_r  <= px_nxt;
      py2_r  <= py_nxt;
      zf2_r  <= zf1_r;
      ctl2_r <= ctl1_r;
    end
    if (en3) begin
      ox_r <= to_q14(64'(px2_r), FRAC_BITS);
      oy_r <= to_q14(64'(py2_r), FRAC_BITS);
      oz_r <= is_circle(ctl2_r.mode) ? 16'sd0 : to_q14(64'(zf2_r), FRAC_BITS);
    end
  end

  assign vout  = v3_r;
  assign dir_x = ox_r;
  assign dir_y = oy_r;
  assign dir_z = oz_r;

endmodule

/* hdl/unit_direction_sampler.sv */
// Data path: the uds_prep front end, the uds_stage chain and the uds_post back end, all registered.
// Throughput: one item per cycle; every stage holds its own valid bit, so a stalled
// output only stops the stages behind it that are full.
// Reset (synchronous, rst_n low) empties the pipeline and sets sample_mode to sphere.
module unit_direction_sampler import uds_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // u_fraction [15:0], v_fraction [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // sample_mode
);

  // Each stage runs at most one CORDIC rotation and one square root bit. The
  // root needs FRAC_BITS + 1 bits, so the chain is as long as the longer of the two.
  localparam int W  = FRAC_BITS + 3;
  localparam int ZW = FRAC_BITS + 2;
  localparam int NW = 2 * FRAC_BITS + 2;
  localparam int NS = (CORDIC_STAGES > FRAC_BITS + 1) ? CORDIC_STAGES : FRAC_BITS + 1;
  localparam logic signed [W-1:0] X0 = W'(cordic_x0(FRAC_BITS));

  mode_t mode_r;

  // Configuration is taken at once; the user writes it only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SPHERE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Chain links: entry k feeds stage k, entry NS leaves the chain.
  logic                  cv   [NS+1];
  logic                  crdy [NS+1];
  logic signed [W-1:0]   cx   [NS+1];
  logic signed [W-1:0]   cy   [NS+1];
  logic signed [31:0]    cang [NS+1];
  logic [NW-1:0]         cn   [NS+1];
  logic [NW-1:0]         cres [NS+1];
  logic signed [ZW-1:0]  czf  [NS+1];
  uds_ctl_t              cctl [NS+1];

  logic signed [15:0] dir_x, dir_y, dir_z;

  // Front end: height, its square and the root operand, plus the folded angle.
  uds_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .vin      (in_tvalid),
    .up_ready (in_tready),
    .u_in     (in_tdata[15:0]),
    .v_in     (in_tdata[31:16]),
    .mode_in  (mode_r),
    .dn_ready (crdy[0]),
    .vout     (cv[0]),
    .ang_out  (cang[0]),
    .n_out    (cn[0]),
    .zf_out   (czf[0]),
    .ctl_out  (cctl[0])
  );

  assign cx[0]   = X0;
  assign cy[0]   = '0;
  assign cres[0] = '0;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_chain
      uds_stage #(
        .FRAC_BITS (FRAC_BITS),
        .IDX       (k),
        .DO_ROT    (k < CORDIC_STAGES && k < ATAN_LEN),
        .DO_ROOT   (k <= FRAC_BITS)
      ) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .vin      (cv[k]),
        .up_ready (crdy[k]),
        .x_in     (cx[k]),
        .y_in     (cy[k]),
        .ang_in   (cang[k]),
        .n_in     (cn[k]),
        .res_in   (cres[k]),
        .zf_in    (czf[k]),
        .ctl_in   (cctl[k]),
        .dn_ready (crdy[k+1]),
        .vout     (cv[k+1]),
        .x_out    (cx[k+1]),
        .y_out    (cy[k+1]),
        .ang_out  (cang[k+1]),
        .n_out    (cn[k+1]),
        .res_out  (cres[k+1]),
        .zf_out   (czf[k+1]),
        .ctl_out  (cctl[k+1])
      );
    end
  endgenerate

  // Back end: undo the half-turn fold, scale by the radius outside circle mode, round and clamp.
  // Its last register is the output register of the result channel.
  uds_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .vin      (cv[NS]),
    .up_ready (crdy[NS]),
    .x_in     (cx[NS]),
    .y_in     (cy[NS]),
    .res_in   (cres[NS]),
    .zf_in    (czf[NS]),
    .ctl_in   (cctl[NS]),
    .dn_ready (out_tready),
    .vout     (out_tvalid),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z)
  );

  assign out_tdata = {dir_z, dir_y, dir_x};

endmodule
